// ===== rtl/sle_pkg.sv =====
// Package for the sorted list engine: field widths, action and status codes,
// the controller state type and the per-cell control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

    localparam int ValueW       = 32;
    localparam int CountW       = 5;
    localparam int DefCapacity  = 16;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_POP    = 2'd3
    } sle_action_t;

    typedef enum logic [2:0] {
        STS_DONE      = 3'd0,
        STS_FOUND     = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_EMPTY     = 3'd3,
        STS_FULL      = 3'd4
    } sle_status_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_APPLY = 1'b1
    } sle_state_t;

    typedef enum logic [1:0] {
        SH_KEEP   = 2'd0,
        SH_INSERT = 2'd1,
        SH_LEFT   = 2'd2
    } sle_shift_t;

    typedef struct packed {
        logic                     capture;
        sle_shift_t               shift;
        logic signed [ValueW-1:0] cmp_value;
        logic signed [ValueW-1:0] ins_value;
    } sle_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sle_cell.sv =====
// One cell of the sorted chain: holds one entry, compares it with the incoming
// value and shifts toward its neighbors. Depends on sle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sle_cell
    import sle_pkg::*;
(
    input  wire logic                     clk,
    input  wire sle_cell_ctrl_t           ctrl,
    input  wire logic                     occupied,
    input  wire logic signed [ValueW-1:0] left_entry,
    input  wire logic                     left_lt,
    input  wire logic signed [ValueW-1:0] right_entry,
    output logic signed [ValueW-1:0]      entry,
    output logic                          lt,
    output logic                          eq
);

    logic signed [ValueW-1:0] entry_reg, entry_next;
    logic                     lt_reg, lt_next;
    logic                     eq_reg, eq_next;

    always_comb
    begin
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        entry_next = entry_reg;
        if (ctrl.capture)
        begin
            lt_next = occupied && (entry_reg < ctrl.cmp_value);
            eq_next = occupied && (entry_reg == ctrl.cmp_value);
        end
        // Cells at or past the target position move; the flags form a prefix.
        case (ctrl.shift)
            SH_INSERT:
            begin
                if (!lt_reg)
                begin
                    entry_next = left_lt ? ctrl.ins_value : left_entry;
                end
            end
            SH_LEFT:
            begin
                if (!lt_reg)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        lt_reg    <= lt_next;
        eq_reg    <= eq_next;
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_list_engine_top.sv =====
// Top level of the sorted list engine: controller, occupancy counter, result
// register and the chain of sle_cell instances. Depends on sle_pkg, sle_cell.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  in      | input     | in_valid / in_ready | action, value
//  out     | output    | out_valid/out_ready | status, popped_value, entry_count
//
// Each transfer has a compare step, in which all cells compare against the
// value, and then a shift step that shifts the chain and loads the result register.
// A new item is taken while the previous result still waits in the output
// register; the shift cycle holds while that register is full and out_ready is low.
// Reset clears the occupancy and the control state; entries need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_engine_top
    import sle_pkg::*;
#(
    parameter int CAPACITY = DefCapacity
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        action,
    input  wire logic signed [ValueW-1:0] value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             status,
    output logic signed [ValueW-1:0] popped_value,
    output logic [CountW-1:0]      entry_count
);

    localparam int OccW = $clog2(CAPACITY + 1);
    localparam logic signed [ValueW-1:0] PopCmpValue = {1'b1, {(ValueW-1){1'b0}}};

    sle_state_t state_reg, state_next;

    logic [OccW-1:0]           occ_reg, occ_next;
    sle_action_t               op_action_reg;
    logic signed [ValueW-1:0]  op_value_reg;

    logic                      out_valid_reg;
    sle_status_t               status_reg, status_next;
    logic signed [ValueW-1:0]  popped_reg, popped_next;

    logic                      in_fire;
    logic                      out_free;
    logic                      apply_fire;
    logic                      found;
    logic                      full;
    sle_shift_t                shift_sel;
    sle_cell_ctrl_t            cell_ctrl;

    logic signed [ValueW-1:0]  cell_entry [CAPACITY];
    logic [CAPACITY-1:0]       cell_lt;
    logic [CAPACITY-1:0]       cell_eq;
    logic [CAPACITY-1:0]       cell_occ;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign found    = |cell_eq;
    assign full     = (occ_reg == OccW'(CAPACITY));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        in_ready   = 1'b0;
        apply_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready   = 1'b1;
            ST_APPLY: apply_fire = out_free;
            default:  in_ready   = 1'b0;
        endcase
    end

    // Outcome of the operation, from the flags captured in the compare cycle.
    always_comb
    begin
        shift_sel   = SH_KEEP;
        status_next = STS_DONE;
        popped_next = '0;
        occ_next    = occ_reg;
        unique case (op_action_reg)
            ACT_INSERT:
            begin
                if (full)
                begin
                    status_next = STS_FULL;
                end
                else
                begin
                    shift_sel = SH_INSERT;
                    occ_next  = occ_reg + OccW'(1);
                end
            end
            ACT_SEARCH:
            begin
                status_next = found ? STS_FOUND : STS_NOT_FOUND;
            end
            ACT_DELETE:
            begin
                if (found)
                begin
                    shift_sel = SH_LEFT;
                    occ_next  = occ_reg - OccW'(1);
                end
                else
                begin
                    status_next = STS_NOT_FOUND;
                end
            end
            ACT_POP:
            begin
                if (occ_reg == '0)
                begin
                    status_next = STS_EMPTY;
                end
                else
                begin
                    // Every occupied cell has lt clear for pop, so the whole chain moves.
                    shift_sel   = SH_LEFT;
                    popped_next = cell_entry[0];
                    occ_next    = occ_reg - OccW'(1);
                end
            end
            default:
            begin
                status_next = STS_DONE;
            end
        endcase
    end

    // A pop compares against the most negative value, so no cell can report
    // less-than and every cell shifts left.
    always_comb
    begin
        cell_ctrl.capture   = in_fire;
        cell_ctrl.shift     = apply_fire ? shift_sel : SH_KEEP;
        cell_ctrl.cmp_value = (sle_action_t'(action) == ACT_POP) ? PopCmpValue : value;
        cell_ctrl.ins_value = op_value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (apply_fire)
            begin
                occ_reg       <= occ_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_action_reg <= sle_action_t'(action);
            op_value_reg  <= value;
        end
        if (apply_fire)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [ValueW-1:0] left_entry;
            logic                     left_lt;
            logic signed [ValueW-1:0] right_entry;
            logic                     lt_raw;

            assign cell_occ[gi] = (OccW'(gi) < occ_reg);

            if (gi == 0)
            begin : g_first
                assign left_entry = op_value_reg;
                assign left_lt    = 1'b1;
            end
            else
            begin : g_mid
                assign left_entry = cell_entry[gi-1];
                assign left_lt    = cell_lt[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_entry = cell_entry[gi];
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[gi+1];
            end

            sle_cell u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .occupied    (cell_occ[gi]),
                .left_entry  (left_entry),
                .left_lt     (left_lt),
                .right_entry (right_entry),
                .entry       (cell_entry[gi]),
                .lt          (lt_raw),
                .eq          (cell_eq[gi])
            );

            assign cell_lt[gi] = lt_raw;
        end
    endgenerate

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign entry_count  = CountW'(occ_reg);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OccW'(CAPACITY))
        else $error("occupancy above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        apply_fire && (op_action_reg == ACT_INSERT) && !full
        |=> occ_reg == $past(occ_reg) + OccW'(1))
        else $error("insert did not grow occupancy");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == STS_FULL) |-> full)
        else $error("full status reported with room left");

    a_apply_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_APPLY) && !in_ready)
        else $error("transfer accepted without an apply cycle");

endmodule

`default_nettype wire

// ===== dv/sorted_list_monitor.sv =====
// Monitor for the sorted list engine: keeps a shadow copy of the sorted list,
// predicts the result of every input transfer and compares result transfers.
// Depends on sle_pkg.
`timescale 1ns / 1ps

module sorted_list_monitor
    import sle_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_ready,
    input  wire logic [1:0]               action,
    input  wire logic signed [ValueW-1:0] value,
    input  wire logic                     out_valid,
    input  wire logic                     out_ready,
    input  wire logic [2:0]               status,
    input  wire logic signed [ValueW-1:0] popped_value,
    input  wire logic [CountW-1:0]        entry_count,
    output int                            error_count,
    output int                            pending
);

    typedef struct packed {
        sle_status_t              st;
        logic signed [ValueW-1:0] popped;
        logic [CountW-1:0]        count;
    } list_result_t;

    logic signed [ValueW-1:0] shadow_list[$];
    list_result_t             expected_results[$];
    list_result_t             oldest;
    int                       errs;

    // Position of the first stored entry that is not less than v.
    function automatic int first_not_below(logic signed [ValueW-1:0] v);
        int i;
        i = 0;
        while (i < shadow_list.size() && shadow_list[i] < v)
            i++;
        return i;
    endfunction

    function automatic list_result_t apply_list_op(logic [1:0] act,
                                                   logic signed [ValueW-1:0] v);
        list_result_t r;
        int           pos;
        bit           hit;
        r.st     = STS_DONE;
        r.popped = '0;
        pos      = first_not_below(v);
        hit      = (pos < shadow_list.size()) && (shadow_list[pos] == v);
        case (act)
            ACT_INSERT:
                if (shadow_list.size() >= DefCapacity)
                    r.st = STS_FULL;
                else
                    shadow_list.insert(pos, v);
            ACT_SEARCH:
                r.st = hit ? STS_FOUND : STS_NOT_FOUND;
            ACT_DELETE:
                if (hit)
                    shadow_list.delete(pos);
                else
                    r.st = STS_NOT_FOUND;
            default:
                if (shadow_list.size() == 0)
                    r.st = STS_EMPTY;
                else
                    r.popped = shadow_list.pop_front();
        endcase
        r.count = CountW'(shadow_list.size());
        return r;
    endfunction

    initial
    begin
        errs        = 0;
        error_count = 0;
        pending     = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_list.delete();
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            // A result can never belong to the item taken in the same cycle,
            // so the result side is checked before the new prediction is queued.
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transfer: status %0d, popped_value %0d, %s %0d",
                           status, popped_value, "entry_count", entry_count);
                    errs++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (status !== oldest.st)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", oldest.st, status);
                        errs++;
                    end
                    if (popped_value !== oldest.popped)
                    begin
                        $error("popped_value mismatch: expected %0d, actual %0d",
                               oldest.popped, popped_value);
                        errs++;
                    end
                    if (entry_count !== oldest.count)
                    begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               oldest.count, entry_count);
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_list_op(action, value));
            pending     <= expected_results.size();
            error_count <= errs;
        end
    end

endmodule

// ===== dv/tb_sorted_list_engine_top.sv =====
// Testbench top for the sorted list engine: clock, reset, stimulus, receiver
// back-pressure, watchdog and verdict. Depends on sle_pkg, sorted_list_monitor
// and the sorted_list_engine_top RTL.
`timescale 1ns / 1ps

module tb_sorted_list_engine_top;
    import sle_pkg::*;

    localparam int                       HalfPeriod  = 6;
    localparam int                       StallLimit  = 2000;
    localparam int                       HoldCycles  = 80;
    localparam int                       PhaseItems  = 325;
    localparam int                       PhaseCount  = 6;
    localparam logic signed [ValueW-1:0] MinValue    = 32'sh8000_0000;
    localparam logic signed [ValueW-1:0] MaxValue    = 32'sh7FFF_FFFF;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               action;
    logic signed [ValueW-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic [2:0]               status;
    logic signed [ValueW-1:0] popped_value;
    logic [CountW-1:0]        entry_count;

    int                       error_count;
    int                       pending;
    bit                       no_gaps;
    bit                       hold_off_req;
    int                       idle_cycles;
    logic signed [ValueW-1:0] recent_values[$];

    sorted_list_engine_top #(.CAPACITY(DefCapacity)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .entry_count  (entry_count)
    );

    sorted_list_monitor monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .entry_count  (entry_count),
        .error_count  (error_count),
        .pending      (pending)
    );

    initial
        clk = 1'b0;

    always #(HalfPeriod) clk = ~clk;

    // Offers one item at a falling edge and returns at the rising edge that
    // completes its transfer.
    task automatic send_item(input sle_action_t act, input logic signed [ValueW-1:0] val);
        @(negedge clk);
        while (!no_gaps && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (act == ACT_INSERT)
        begin
            recent_values.push_back(val);
            if (recent_values.size() > 32)
                void'(recent_values.pop_front());
        end
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Mostly small values so that searches and deletes hit and duplicates occur.
    function automatic logic signed [ValueW-1:0] random_operand();
        int pick;
        int offset;
        pick   = $urandom_range(0, 9);
        offset = $urandom_range(0, 24);
        if (pick == 0)
            return $urandom;
        if (pick == 1)
        begin
            case ($urandom_range(0, 3))
                0: return MinValue;
                1: return MaxValue;
                2: return '0;
                default: return -1;
            endcase
        end
        if (pick <= 4 && recent_values.size() > 0)
            return recent_values[$urandom_range(0, recent_values.size() - 1)];
        return offset - 12;
    endfunction

    // Receiver side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HoldCycles) @(negedge clk);
                hold_off_req = 1'b0;
                out_ready <= 1'b1;
            end
            else
                out_ready <= no_gaps || ($urandom_range(0, 99) >= 8);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < StallLimit)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("sorted_list_engine_top regression: fail");
        $finish;
    end

    initial
    begin
        int          insert_share;
        int          roll;
        sle_action_t act;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_INSERT;
        value        = '0;
        no_gaps      = 1'b0;
        hold_off_req = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-store cases, extremes, duplicates, hits and misses,
        // then fill the store and try one insert too many.
        send_item(ACT_POP, 123);
        send_item(ACT_DELETE, 0);
        send_item(ACT_SEARCH, 0);
        send_item(ACT_INSERT, MaxValue);
        send_item(ACT_INSERT, MinValue);
        send_item(ACT_INSERT, 0);
        send_item(ACT_INSERT, 0);
        send_item(ACT_INSERT, -1);
        send_item(ACT_SEARCH, 0);
        send_item(ACT_SEARCH, 1);
        send_item(ACT_DELETE, 0);
        send_item(ACT_DELETE, 1);
        send_item(ACT_POP, -1);
        for (int k = 0; k < 13; k++)
            send_item(ACT_INSERT, k * 3 - 20);
        send_item(ACT_INSERT, 5);
        wait_for_drain();

        for (int phase = 0; phase < PhaseCount; phase++)
        begin
            case (phase % 3)
                0: insert_share = 40;
                1: insert_share = 75;
                default: insert_share = 15;
            endcase
            no_gaps = (phase == 1);
            if (phase == 3)
                hold_off_req = 1'b1;
            for (int n = 0; n < PhaseItems; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < insert_share)
                    act = ACT_INSERT;
                else
                begin
                    case ($urandom_range(0, 2))
                        0: act = ACT_SEARCH;
                        1: act = ACT_DELETE;
                        default: act = ACT_POP;
                    endcase
                end
                send_item(act, random_operand());
            end
            // After phases 2 and 5 the sender pauses until every result of the phase has come back.
            if (phase == 2 || phase == PhaseCount - 1)
                wait_for_drain();
        end

        if (error_count == 0 && pending == 0)
            $display("sorted_list_engine_top regression: pass");
        else
            $display("sorted_list_engine_top regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sle_pkg.sv
rtl/sle_cell.sv
rtl/sorted_list_engine_top.sv
dv/sorted_list_monitor.sv
dv/tb_sorted_list_engine_top.sv
